// ----- rtl/hrws_pkg.sv -----
// ----------------------------------------------------------------------------
// hrws_pkg: shared types and constants of the heart-rate stress sequencer
// Window, scan and session sizes, command and mode codes, breathing-phase
// lengths, the score mapping and the packed result layout.
// ----------------------------------------------------------------------------
`default_nettype none

package hrws_pkg;

    localparam int WINDOW_SIZE    = 60;
    localparam int SCAN_LENGTH    = 60;
    localparam int SESSION_LENGTH = 300;

    localparam int WIN_AW  = $clog2(WINDOW_SIZE);
    localparam int SCAN_W  = $clog2(SCAN_LENGTH + 1);
    localparam int SESS_W  = $clog2(SESSION_LENGTH + 1);

    // live stress starts once five seconds of the session have passed
    localparam int LIVE_DELAY = 5;
    localparam int LIVE_LAST  = SESSION_LENGTH - LIVE_DELAY;

    localparam int HR_W      = 8;
    localparam int SCORE_W   = 7;
    localparam int PLEFT_W   = 4;
    localparam int STYLE_W   = 2;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 32;

    localparam int SCORE_MAX = 100;
    localparam int SCORE_MIN = 10;
    localparam int SPREAD_GAIN = 8;
    // smallest spread whose raw score drops below the floor
    localparam int SPREAD_CLAMP = (SCORE_MAX - SCORE_MIN) / SPREAD_GAIN + 1;

    localparam int PHASE_LEFT_MAX = 8;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SCAN   = 2'd1,
        CMD_BREATH = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SCAN   = 2'd1,
        MODE_BREATH = 2'd2
    } mode_t;

    localparam logic [STYLE_W-1:0] STYLE_BOX = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_478 = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_408 = 2'd2;

    typedef struct packed {
        logic [5:0]         pad;
        logic               session_done;
        logic               phase_began;
        logic [PLEFT_W-1:0] phase_left;
        logic [1:0]         phase;
        logic [SCORE_W-1:0] live_stress;
        logic               live_valid;
        logic [SCORE_W-1:0] score;
        logic               score_valid;
        logic [1:0]         mode;
    } res_t;

    function automatic logic [PLEFT_W-1:0] phase_dur(input logic [STYLE_W-1:0] style,
                                                     input logic [1:0] ph);
        logic [PLEFT_W-1:0] d;
        case (style)
            STYLE_478: begin
                case (ph)
                    2'd0:    d = 4'd4;
                    2'd1:    d = 4'd7;
                    2'd2:    d = 4'd8;
                    default: d = 4'd0;
                endcase
            end
            STYLE_408: begin
                case (ph)
                    2'd0:    d = 4'd4;
                    2'd1:    d = 4'd0;
                    2'd2:    d = 4'd8;
                    default: d = 4'd0;
                endcase
            end
            default: d = 4'd4;
        endcase
        return d;
    endfunction

    // first following phase with a nonzero length
    function automatic logic [1:0] next_phase(input logic [STYLE_W-1:0] style,
                                              input logic [1:0] ph);
        logic [1:0] p;
        logic [1:0] res;
        logic       found;
        p     = ph;
        res   = ph;
        found = 1'b0;
        for (int k = 0; k < 4; k++) begin
            p = p + 2'd1;
            if (!found && phase_dur(style, p) != '0) begin
                res   = p;
                found = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic [SCORE_W-1:0] score_of(input logic [HR_W-1:0] spread);
        logic [SCORE_W-1:0] s;
        if (spread >= HR_W'(SPREAD_CLAMP)) begin
            s = SCORE_W'(SCORE_MIN);
        end else begin
            s = SCORE_W'(SCORE_MAX) - SCORE_W'({spread[3:0], 3'b000});
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/heart_rate_window_stress_sequencer.sv -----
// A tick transaction issues its window reads in ST_SCAN, then passes through ST_DRAIN and
// ST_FINISH before its result is registered; a command goes from ST_IDLE straight to ST_FINISH.
// A tick makes one RAM read a cycle through one min/max unit, then drains and finishes;
// s_tready is high only in the idle state, so a new transaction waits until the last one is done.
// A result waiting on m_tready holds the next transaction in its finish step until it drains.
// Reset (aresetn low, synchronous) empties the window, idles the mode, clears the style.
// ----------------------------------------------------------------------------
// heart_rate_window_stress_sequencer: scan and breathing-session sequencer
// Keeps a window of heart-rate samples in RAM with per-entry valid bits and
// derives scan scores and live stress from the window spread.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_window_stress_sequencer (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hrws_pkg::STYLE_W-1:0]        cfg_wr_data,   // breath_style
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [hrws_pkg::IN_DATA_W-1:0]      s_tdata,       // [7:0] heart_rate
    input  wire logic [1:0]                          s_tuser,       // [1:0] cmd
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] mode, [2] score_valid, [9:3] score, [10] live_valid,
    // [17:11] live_stress, [19:18] phase, [23:20] phase_left,
    // [24] phase_began, [25] session_done, [31:26] zero
    output logic      [hrws_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import hrws_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    mode_t               mode_reg, mode_next;
    logic [SCAN_W-1:0]   scan_left_reg, scan_left_next;
    logic [SESS_W-1:0]   session_left_reg, session_left_next;
    logic [1:0]          phase_reg, phase_next;
    logic [PLEFT_W-1:0]  phase_left_reg, phase_left_next;
    logic [SCORE_W-1:0]  live_level_reg, live_level_next;
    logic                live_seen_reg, live_seen_next;
    logic [STYLE_W-1:0]  style_reg, style_next;
    logic [WINDOW_SIZE-1:0] valid_reg, valid_next;
    logic [WIN_AW-1:0]   wp_reg, wp_next;
    logic [WIN_AW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                feed_reg, feed_next;
    logic                vbit_reg, vbit_next;
    logic                m_valid_reg, m_valid_next;
    res_t                m_data_reg, m_data_next;

    logic                s_acc;
    cmd_t                s_cmd;
    logic                win_we;
    logic [HR_W-1:0]     ram_rdata;
    logic [HR_W-1:0]     mm_sample;
    logic [HR_W-1:0]     spread;
    logic [SCORE_W-1:0]  win_score;
    logic [1:0]          nph;

    assign s_cmd    = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign win_we   = s_acc && (s_cmd == CMD_TICK) && (s_tdata != '0);

    hrws_ram #(
        .WIDTH (HR_W),
        .DEPTH (WINDOW_SIZE)
    ) u_window (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (wp_reg),
        .wdata (s_tdata),
        .raddr (rd_cnt_reg),
        .rdata (ram_rdata)
    );

    // entries never written since the last clear read as empty
    assign mm_sample = vbit_reg ? ram_rdata : '0;

    hrws_minmax u_minmax (
        .aclk   (aclk),
        .clear  (s_acc),
        .en     (feed_reg),
        .sample (mm_sample),
        .spread (spread)
    );

    assign win_score = score_of(spread);
    assign nph       = next_phase(style_reg, phase_reg);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        mode_next         = mode_reg;
        scan_left_next    = scan_left_reg;
        session_left_next = session_left_reg;
        phase_next        = phase_reg;
        phase_left_next   = phase_left_reg;
        live_level_next   = live_level_reg;
        live_seen_next    = live_seen_reg;
        style_next        = cfg_wr_en ? cfg_wr_data : style_reg;
        valid_next        = valid_reg;
        wp_next           = wp_reg;
        rd_cnt_next       = rd_cnt_reg;
        feed_next         = 1'b0;
        vbit_next         = vbit_reg;
        m_valid_next      = (m_valid_reg && m_tready) ? 1'b0 : m_valid_reg;
        m_data_next       = m_data_reg;

        if (win_we) begin
            valid_next[wp_reg] = 1'b1;
            wp_next = (wp_reg == WIN_AW'(WINDOW_SIZE - 1)) ? '0 : wp_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    cmd_next    = s_cmd;
                    rd_cnt_next = '0;
                    state_next  = (s_cmd == CMD_TICK) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                // issue one read a cycle; data and valid bit land next cycle
                vbit_next   = valid_reg[rd_cnt_reg];
                feed_next   = 1'b1;
                if (rd_cnt_reg == WIN_AW'(WINDOW_SIZE - 1)) begin
                    rd_cnt_next = '0;
                    state_next  = ST_DRAIN;
                end else begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next = '0;
                    case (cmd_reg)
                        CMD_TICK: begin
                            if (mode_reg == MODE_SCAN) begin
                                if (scan_left_reg <= SCAN_W'(1)) begin
                                    scan_left_next          = '0;
                                    mode_next               = MODE_IDLE;
                                    m_data_next.score_valid = 1'b1;
                                    m_data_next.score       = win_score;
                                end else begin
                                    scan_left_next = scan_left_reg - 1'b1;
                                end
                            end else if (mode_reg == MODE_BREATH) begin
                                if (session_left_reg <= SESS_W'(LIVE_LAST)) begin
                                    live_level_next = win_score;
                                    live_seen_next  = 1'b1;
                                end
                                if (session_left_reg != '0) begin
                                    if (phase_left_reg <= PLEFT_W'(1)) begin
                                        phase_next              = nph;
                                        phase_left_next         = phase_dur(style_reg, nph);
                                        m_data_next.phase_began = 1'b1;
                                    end else begin
                                        phase_left_next = phase_left_reg - 1'b1;
                                    end
                                    session_left_next = session_left_reg - 1'b1;
                                end else begin
                                    mode_next                = MODE_IDLE;
                                    m_data_next.session_done = 1'b1;
                                end
                            end
                        end
                        CMD_SCAN: begin
                            if (mode_reg == MODE_IDLE) begin
                                mode_next      = MODE_SCAN;
                                scan_left_next = SCAN_W'(SCAN_LENGTH);
                                valid_next     = '0;
                            end
                        end
                        CMD_BREATH: begin
                            if (mode_reg == MODE_IDLE) begin
                                mode_next               = MODE_BREATH;
                                session_left_next       = SESS_W'(SESSION_LENGTH);
                                valid_next              = '0;
                                live_seen_next          = 1'b0;
                                live_level_next         = '0;
                                phase_next              = 2'd0;
                                phase_left_next         = phase_dur(style_reg, 2'd0);
                                m_data_next.phase_began = 1'b1;
                            end
                        end
                        default: begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                    m_data_next.mode        = mode_next;
                    m_data_next.live_valid  = live_seen_next;
                    m_data_next.live_stress = live_seen_next ? live_level_next : '0;
                    m_data_next.phase       = phase_next;
                    m_data_next.phase_left  = phase_left_next;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= CMD_TICK;
            mode_reg         <= MODE_IDLE;
            scan_left_reg    <= SCAN_W'(SCAN_LENGTH);
            session_left_reg <= SESS_W'(SESSION_LENGTH);
            phase_reg        <= '0;
            phase_left_reg   <= '0;
            live_level_reg   <= '0;
            live_seen_reg    <= 1'b0;
            style_reg        <= STYLE_BOX;
            valid_reg        <= '0;
            wp_reg           <= '0;
            rd_cnt_reg       <= '0;
            feed_reg         <= 1'b0;
            vbit_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            mode_reg         <= mode_next;
            scan_left_reg    <= scan_left_next;
            session_left_reg <= session_left_next;
            phase_reg        <= phase_next;
            phase_left_reg   <= phase_left_next;
            live_level_reg   <= live_level_next;
            live_seen_reg    <= live_seen_next;
            style_reg        <= style_next;
            valid_reg        <= valid_next;
            wp_reg           <= wp_next;
            rd_cnt_reg       <= rd_cnt_next;
            feed_reg         <= feed_next;
            vbit_reg         <= vbit_next;
            m_valid_reg      <= m_valid_next;
            m_data_reg       <= m_data_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hrws_ram.sv -----
// ----------------------------------------------------------------------------
// hrws_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hrws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/hrws_minmax.sv -----
// ----------------------------------------------------------------------------
// hrws_minmax: running minimum and maximum of nonzero samples
// Takes one sample per enabled cycle and presents the spread of what it saw.
// ----------------------------------------------------------------------------
`default_nettype none

module hrws_minmax (
    input  wire logic                     aclk,
    input  wire logic                     clear,
    input  wire logic                     en,
    input  wire logic [hrws_pkg::HR_W-1:0] sample,
    output logic      [hrws_pkg::HR_W-1:0] spread
);
    import hrws_pkg::*;

    logic [HR_W-1:0] lo_reg;
    logic [HR_W-1:0] hi_reg;
    logic            seen_reg;
    logic            take;

    // zero means no reading: skip it
    assign take = en && (sample != '0);

    always_ff @(posedge aclk) begin
        if (clear) begin
            seen_reg <= 1'b0;
        end else if (take) begin
            seen_reg <= 1'b1;
            if (!seen_reg || sample < lo_reg) begin
                lo_reg <= sample;
            end
            if (!seen_reg || sample > hi_reg) begin
                hi_reg <= sample;
            end
        end
    end

    assign spread = seen_reg ? (hi_reg - lo_reg) : '0;

endmodule

`default_nettype wire

// ----- rtl/hrws_checker.sv -----
// ----------------------------------------------------------------------------
// hrws_checker: port-level checks of the heart-rate stress sequencer
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module hrws_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                cfg_wr_en,
    input wire logic [hrws_pkg::STYLE_W-1:0]        cfg_wr_data,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic [hrws_pkg::IN_DATA_W-1:0]      s_tdata,
    input wire logic [1:0]                          s_tuser,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [hrws_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import hrws_pkg::*;

    res_t r;
    assign r = res_t'(m_tdata);

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a transaction is in work");

    a_score_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.score_valid |->
            r.mode == MODE_IDLE && !r.session_done &&
            r.score >= SCORE_W'(SCORE_MIN) && r.score <= SCORE_W'(SCORE_MAX))
        else $error("bad scan score result");

    a_live_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.phase_left <= PLEFT_W'(PHASE_LEFT_MAX) &&
            (r.live_valid || r.live_stress == '0) && r.pad == '0)
        else $error("bad phase or live stress field");

endmodule

bind heart_rate_window_stress_sequencer hrws_checker u_hrws_checker (.*);

`default_nettype wire
